// ===== rtl/scad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scad_pkg
// Types, scan codes and the two-column keymap of the scan code set 1 decoder.
// ----------------------------------------------------------------------------
package scad_pkg;

   typedef enum logic [1:0] {
      EVT_NONE    = 2'd0,
      EVT_CHAR    = 2'd1,
      EVT_UNKNOWN = 2'd2
   } event_kind_type;

   localparam logic [7:0] SC_PREFIX   = 8'hE0;
   localparam logic [6:0] SC_CTRL     = 7'h1D;
   localparam logic [6:0] SC_LSHIFT   = 7'h2A;
   localparam logic [6:0] SC_RSHIFT   = 7'h36;
   localparam logic [6:0] SC_ALT      = 7'h38;
   localparam logic [6:0] SC_CAPS     = 7'h3A;
   localparam logic [6:0] SC_KEY_LAST = 7'h3A;

   localparam int KEYMAP_DEPTH = 64;

   // unshifted column, indexed by make code
   localparam logic [6:0] KEYMAP_LO [KEYMAP_DEPTH] = '{
      7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
      7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
      7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73,
      7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   // shifted column, indexed by make code
   localparam logic [6:0] KEYMAP_HI [KEYMAP_DEPTH] = '{
      7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
      7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
      7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53,
      7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
      7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   // keys whose column follows shift alone (digits and punctuation)
   function automatic logic shift_only_key(input logic [6:0] code);
      return (code <= 7'h0D) || (code == 7'h29) || (code == 7'h1A) ||
             (code == 7'h1B) || (code == 7'h2B) || (code == 7'h27) ||
             (code == 7'h28) || (code == 7'h33) || (code == 7'h34) ||
             (code == 7'h35);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/scancode_to_ascii_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_to_ascii_decoder_core
// Scan code set 1 byte stream to ASCII with ctrl, shift, alt and caps state.
// ----------------------------------------------------------------------------
// Every accepted byte gives exactly one result: a character, an unknown-key
// report, or nothing (prefix, break or modifier), together with the modifier
// flags as they stand after that byte. The block takes one byte per cycle
// unless a waiting result is stalled; the result is registered and appears
// in the cycle after the transfer, and a new byte is taken while that result
// waits as long as the result side is ready in the same cycle. The keymap lookup and the flag update sit
// between the request port and that single result register.
// ----------------------------------------------------------------------------
module scancode_to_ascii_decoder_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire logic [7:0]                req_scan_byte,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      scad_pkg::event_kind_type  rsp_event_kind,
   output      logic [6:0]                rsp_ascii_char,
   output      logic                      rsp_ctrl_flag,
   output      logic                      rsp_shift_flag,
   output      logic                      rsp_alt_flag,
   output      logic                      rsp_caps_flag
);
   import scad_pkg::*;

   logic           ext_ff, ext_in;
   logic           ctrl_ff, ctrl_in;
   logic           shift_ff, shift_in;
   logic           alt_ff, alt_in;
   logic           caps_ff, caps_in;
   logic           rsp_valid_ff, rsp_valid_in;
   event_kind_type kind_ff, kind_in;
   logic [6:0]     char_ff, char_in;

   logic           req_xfer;
   logic [6:0]     code;
   logic           col;
   logic [6:0]     key_char;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign code      = req_scan_byte[6:0];
   assign col       = shift_only_key(code) ? shift_ff : (shift_ff ^ caps_ff);
   assign key_char  = col ? KEYMAP_HI[code[5:0]] : KEYMAP_LO[code[5:0]];

   always_comb begin
      ext_in   = ext_ff;
      ctrl_in  = ctrl_ff;
      shift_in = shift_ff;
      alt_in   = alt_ff;
      caps_in  = caps_ff;
      kind_in  = EVT_NONE;
      char_in  = 7'd0;
      if (req_scan_byte == SC_PREFIX) begin
         ext_in = 1'b1;
      end else begin
         ext_in = 1'b0;
         if (req_scan_byte[7]) begin
            if (code == SC_CTRL) begin
               ctrl_in = 1'b0;
            end else if (code == SC_ALT) begin
               alt_in = 1'b0;
            end else if (!ext_ff && (code == SC_LSHIFT || code == SC_RSHIFT)) begin
               shift_in = 1'b0;
            end
         end else if (ext_ff) begin
            priority if (code == SC_CTRL) begin
               ctrl_in = 1'b1;
            end else if (code == SC_ALT) begin
               alt_in = 1'b1;
            end else begin
               kind_in = EVT_UNKNOWN;
            end
         end else if (code != 7'd0 && code <= SC_KEY_LAST) begin
            priority if (key_char != 7'd0) begin
               kind_in = EVT_CHAR;
               char_in = key_char;
            end else if (code == SC_CTRL) begin
               ctrl_in = 1'b1;
            end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
               shift_in = 1'b1;
            end else if (code == SC_ALT) begin
               alt_in = 1'b1;
            end else if (code == SC_CAPS) begin
               caps_in = !caps_ff;
            end
         end else begin
            kind_in = EVT_UNKNOWN;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff       <= 1'b0;
         ctrl_ff      <= 1'b0;
         shift_ff     <= 1'b0;
         alt_ff       <= 1'b0;
         caps_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            ext_ff   <= ext_in;
            ctrl_ff  <= ctrl_in;
            shift_ff <= shift_in;
            alt_ff   <= alt_in;
            caps_ff  <= caps_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff <= kind_in;
         char_ff <= char_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_ctrl_flag  = ctrl_ff;
   assign rsp_shift_flag = shift_ff;
   assign rsp_alt_flag   = alt_ff;
   assign rsp_caps_flag  = caps_ff;

endmodule
`default_nettype wire

// ===== rtl/scad_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scad_checker
// Port-level checks of the scan code decoder, bound to the decoder core module.
// ----------------------------------------------------------------------------
module scad_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic [7:0]                req_scan_byte,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire scad_pkg::event_kind_type  rsp_event_kind,
   input wire logic [6:0]                rsp_ascii_char,
   input wire logic                      rsp_ctrl_flag,
   input wire logic                      rsp_shift_flag,
   input wire logic                      rsp_alt_flag,
   input wire logic                      rsp_caps_flag
);
   import scad_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind) &&
      $stable(rsp_ascii_char) && $stable(rsp_caps_flag))
      else $error("stalled result changed");

   // every request transfer gives a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("request transfer without result");

   // character code only with a character event
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EVT_CHAR |-> rsp_ascii_char == 7'd0)
      else $error("character code without character event");

   // prefix emits nothing and leaves the modifiers alone
   a_prefix_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_scan_byte == SC_PREFIX ##1 rsp_valid |->
      rsp_event_kind == EVT_NONE && rsp_ctrl_flag == $past(rsp_ctrl_flag) &&
      rsp_alt_flag == $past(rsp_alt_flag) && rsp_shift_flag == $past(rsp_shift_flag))
      else $error("prefix changed output state");

endmodule

bind scancode_to_ascii_decoder_core scad_checker u_scad_checker (.*);
`default_nettype wire
